// ===== rtl/sco_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sco_pkg
// Shared constants and types for the segment versus circle obstacle check.
// ----------------------------------------------------------------------------
package sco_pkg;

    localparam int MAX_OBSTACLES = 64;
    localparam int IDX_W         = $clog2(MAX_OBSTACLES);
    localparam int CNT_W         = 7;
    localparam int COORD_W       = 16;
    localparam int RAD_W         = 15;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int LEN_W         = 2 * DIFF_W;
    localparam int DOT_W         = 2 * DIFF_W + 2;
    localparam int MUL_W         = 20;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int FRAC_W        = 16;
    localparam int T_W           = FRAC_W + 1;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic        [RAD_W-1:0]   r;
    } obstacle_t;

    typedef struct packed {
        logic                     is_write;
        logic [IDX_W-1:0]         slot;
        obstacle_t                obs;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== rtl/sco_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sco_in_if
// Item channel: table writes and segment queries.
// ----------------------------------------------------------------------------
interface sco_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [5:0]                          slot;
    logic signed [sco_pkg::COORD_W-1:0]  centre_x;
    logic signed [sco_pkg::COORD_W-1:0]  centre_y;
    logic [sco_pkg::RAD_W-1:0]           radius;
    logic signed [sco_pkg::COORD_W-1:0]  start_x;
    logic signed [sco_pkg::COORD_W-1:0]  start_y;
    logic signed [sco_pkg::COORD_W-1:0]  end_x;
    logic signed [sco_pkg::COORD_W-1:0]  end_y;

    modport source (output valid, op, slot, centre_x, centre_y, radius,
                    start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, op, slot, centre_x, centre_y, radius,
                    start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== rtl/sco_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sco_out_if
// Result channel: hit flag and write acknowledge.
// ----------------------------------------------------------------------------
interface sco_out_if;
    logic valid;
    logic ready;
    logic blocked;
    logic was_write;

    modport source (output valid, blocked, was_write, input ready);
    modport sink   (input valid, blocked, was_write, output ready);
endinterface

// ===== rtl/sco_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sco_cfg_if
// Configuration write channel for the obstacle count register.
// ----------------------------------------------------------------------------
interface sco_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sco_pkg::CNT_W-1:0]   obstacle_count;

    modport source (output valid, obstacle_count, input ready);
    modport sink   (input valid, obstacle_count, output ready);
endinterface

// ===== rtl/sco_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sco_front
// Accepts items, classifies them and precomputes the segment direction.
// ----------------------------------------------------------------------------
module sco_front (
    sco_in_if.sink              in_ch,
    input  sco_pkg::q_status_t  q_status,
    output logic                push,
    output sco_pkg::cmd_t       cmd
);

    // Take an item whenever the queue has room
    assign in_ch.ready = !q_status.full;
    assign push        = in_ch.valid && in_ch.ready;

    // Build the command word
    always_comb
    begin
        cmd.is_write = (in_ch.op == sco_pkg::OP_WRITE);
        cmd.slot     = in_ch.slot;
        cmd.obs.cx   = in_ch.centre_x;
        cmd.obs.cy   = in_ch.centre_y;
        cmd.obs.r    = in_ch.radius;
        cmd.sx       = in_ch.start_x;
        cmd.sy       = in_ch.start_y;
        cmd.dx       = sco_pkg::DIFF_W'(in_ch.end_x) - sco_pkg::DIFF_W'(in_ch.start_x);
        cmd.dy       = sco_pkg::DIFF_W'(in_ch.end_y) - sco_pkg::DIFF_W'(in_ch.start_y);
    end

endmodule

// ===== rtl/sco_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sco_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module sco_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sco_pkg::cmd_t       push_data,
    input  logic                pop,
    output sco_pkg::cmd_t       pop_data,
    output sco_pkg::q_status_t  status
);

    sco_pkg::cmd_t                   store_reg [sco_pkg::QDEPTH];
    logic [sco_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [sco_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [sco_pkg::QPTR_W:0]        fill_reg;
    logic [sco_pkg::QPTR_W:0]        fill_next;

    assign status.full  = (fill_reg == (sco_pkg::QPTR_W+1)'(sco_pkg::QDEPTH));
    assign status.empty = (fill_reg == '0);
    assign pop_data     = store_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/sco_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sco_back
// Executes commands: table writes, and queries that walk the obstacle table
// with a shared multiplier pair and a bit-serial divider.
// ----------------------------------------------------------------------------
module sco_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [sco_pkg::CNT_W-1:0]  obstacle_count,
    input  sco_pkg::q_status_t         q_status,
    input  sco_pkg::cmd_t              q_data,
    output logic                       pop,
    sco_out_if.source                  out_ch
);

    typedef enum logic [3:0] {
        S_IDLE, S_LEN, S_LSUM, S_RD, S_MUL, S_DOT, S_CLAMP, S_DIV,
        S_PROJ, S_OFS, S_SQ, S_CMP, S_DONE
    } state_t;

    state_t                              state_reg;
    sco_pkg::cmd_t                       cmd_reg;
    sco_pkg::obstacle_t                  ent_reg;
    sco_pkg::obstacle_t                  mem [sco_pkg::MAX_OBSTACLES];
    logic [sco_pkg::CNT_W-1:0]           idx_reg;
    logic [sco_pkg::CNT_W-1:0]           limit;
    logic [sco_pkg::LEN_W-1:0]           len2_reg;
    logic signed [sco_pkg::DOT_W-1:0]    dot_reg;
    logic [sco_pkg::LEN_W:0]             rem_reg;
    logic [sco_pkg::LEN_W:0]             rem_shift;
    logic [sco_pkg::T_W-1:0]             t_reg;
    logic [3:0]                          step_reg;
    logic signed [sco_pkg::PROD_W-1:0]   pa_reg;
    logic signed [sco_pkg::PROD_W-1:0]   pb_reg;
    logic [2*sco_pkg::RAD_W-1:0]         r2_reg;
    logic signed [sco_pkg::MUL_W-1:0]    ex_reg;
    logic signed [sco_pkg::MUL_W-1:0]    ey_reg;
    logic signed [sco_pkg::MUL_W-1:0]    ma0, mb0, ma1, mb1;
    logic signed [sco_pkg::PROD_W:0]     psum;
    logic signed [sco_pkg::MUL_W-1:0]    px, py;
    logic signed [sco_pkg::DOT_W-1:0]    len2_s;
    logic                                hit_reg;
    logic                                wr_reg;
    logic                                out_valid_reg;
    logic                                out_blocked_reg;
    logic                                out_write_reg;
    logic                                out_free;

    // Saturate the count to the table size
    assign limit = (obstacle_count > sco_pkg::CNT_W'(sco_pkg::MAX_OBSTACLES))
                 ? sco_pkg::CNT_W'(sco_pkg::MAX_OBSTACLES) : obstacle_count;

    assign pop      = (state_reg == S_IDLE) && !q_status.empty;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.blocked   = out_blocked_reg;
    assign out_ch.was_write = out_write_reg;

    assign psum      = (sco_pkg::PROD_W+1)'(pa_reg) + (sco_pkg::PROD_W+1)'(pb_reg);
    assign rem_shift = {rem_reg[sco_pkg::LEN_W-1:0], 1'b0};
    assign len2_s    = sco_pkg::DOT_W'(len2_reg);

    // Closest point on the segment, floor of the scaled step
    assign px = sco_pkg::MUL_W'(cmd_reg.sx) + sco_pkg::MUL_W'(pa_reg >>> sco_pkg::FRAC_W);
    assign py = sco_pkg::MUL_W'(cmd_reg.sy) + sco_pkg::MUL_W'(pb_reg >>> sco_pkg::FRAC_W);

    // Select multiplier operands for the current step
    always_comb
    begin
        ma0 = sco_pkg::MUL_W'(cmd_reg.dx);
        mb0 = sco_pkg::MUL_W'(cmd_reg.dx);
        ma1 = sco_pkg::MUL_W'(cmd_reg.dy);
        mb1 = sco_pkg::MUL_W'(cmd_reg.dy);
        case (state_reg)
            S_MUL:
            begin
                ma0 = sco_pkg::MUL_W'(ent_reg.cx) - sco_pkg::MUL_W'(cmd_reg.sx);
                ma1 = sco_pkg::MUL_W'(ent_reg.cy) - sco_pkg::MUL_W'(cmd_reg.sy);
            end
            S_PROJ:
            begin
                ma0 = signed'(sco_pkg::MUL_W'(t_reg));
                ma1 = signed'(sco_pkg::MUL_W'(t_reg));
            end
            S_SQ:
            begin
                ma0 = ex_reg;
                mb0 = ex_reg;
                ma1 = ey_reg;
                mb1 = ey_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Store table writes and read the current table entry
    always_ff @(posedge clk)
    begin
        if (pop && q_data.is_write)
            mem[q_data.slot] <= q_data.obs;
        if (state_reg == S_RD)
            ent_reg <= mem[idx_reg[sco_pkg::IDX_W-1:0]];
    end

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            out_blocked_reg <= 1'b0;
            out_write_reg   <= 1'b0;
            idx_reg         <= '0;
            step_reg        <= '0;
            hit_reg         <= 1'b0;
            wr_reg          <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        cmd_reg <= q_data;
                        wr_reg  <= q_data.is_write;
                        hit_reg <= 1'b0;
                        idx_reg <= '0;
                        state_reg <= q_data.is_write ? S_DONE : S_LEN;
                    end
                end
                S_LEN:
                begin
                    pa_reg    <= ma0 * mb0;
                    pb_reg    <= ma1 * mb1;
                    state_reg <= S_LSUM;
                end
                S_LSUM:
                begin
                    len2_reg  <= sco_pkg::LEN_W'(psum);
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    if (len2_reg == '0 || idx_reg == limit)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    pa_reg    <= ma0 * mb0;
                    pb_reg    <= ma1 * mb1;
                    state_reg <= S_DOT;
                end
                S_DOT:
                begin
                    dot_reg   <= sco_pkg::DOT_W'(psum);
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    // Clamp the projection to the segment or start the divide
                    if (dot_reg <= 0)
                    begin
                        t_reg     <= '0;
                        state_reg <= S_PROJ;
                    end
                    else if (dot_reg >= len2_s)
                    begin
                        t_reg     <= sco_pkg::T_W'(1) << sco_pkg::FRAC_W;
                        state_reg <= S_PROJ;
                    end
                    else
                    begin
                        rem_reg   <= (sco_pkg::LEN_W+1)'(dot_reg);
                        t_reg     <= '0;
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    // One quotient bit per cycle
                    if (rem_shift >= (sco_pkg::LEN_W+1)'(len2_reg))
                    begin
                        rem_reg <= rem_shift - (sco_pkg::LEN_W+1)'(len2_reg);
                        t_reg   <= {t_reg[sco_pkg::T_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        t_reg   <= {t_reg[sco_pkg::T_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 4'(sco_pkg::FRAC_W - 1))
                        state_reg <= S_PROJ;
                end
                S_PROJ:
                begin
                    pa_reg    <= ma0 * mb0;
                    pb_reg    <= ma1 * mb1;
                    state_reg <= S_OFS;
                end
                S_OFS:
                begin
                    ex_reg    <= sco_pkg::MUL_W'(ent_reg.cx) - px;
                    ey_reg    <= sco_pkg::MUL_W'(ent_reg.cy) - py;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    pa_reg    <= ma0 * mb0;
                    pb_reg    <= ma1 * mb1;
                    r2_reg    <= ent_reg.r * ent_reg.r;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (psum < signed'((sco_pkg::PROD_W+1)'(r2_reg)))
                    begin
                        hit_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_DONE:
                begin
                    // Hold until the output register frees up
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_blocked_reg <= hit_reg;
                        out_write_reg   <= wr_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/segment_circle_obstacle_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_circle_obstacle_check
// The back end handles one item at a time: a write goes straight to S_DONE, and a
// query walks up to 64 obstacles, dividing only when the projection is not clamped.
// A query stops at the first hit; the queue buffers two items ahead of the back end.
// Reset clears the count register, queue and control; the table is not reset.
// ----------------------------------------------------------------------------
module segment_circle_obstacle_check (
    input  logic        clk,
    input  logic        rst_n,
    sco_in_if.sink      in_ch,
    sco_cfg_if.sink     cfg_ch,
    sco_out_if.source   out_ch
);

    logic [sco_pkg::CNT_W-1:0]  count_reg;
    sco_pkg::q_status_t         q_status;
    sco_pkg::cmd_t              push_cmd;
    sco_pkg::cmd_t              pop_cmd;
    logic                       push;
    logic                       pop;

    // Count register write
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_ch.valid && cfg_ch.ready)
            count_reg <= cfg_ch.obstacle_count;
    end

    sco_front u_front (
        .in_ch    (in_ch),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    sco_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .pop_data  (pop_cmd),
        .status    (q_status)
    );

    sco_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .obstacle_count (count_reg),
        .q_status       (q_status),
        .q_data         (pop_cmd),
        .pop            (pop),
        .out_ch         (out_ch)
    );

endmodule
